@@ hw/rtl/ppv_pkg.sv @@
// shared constants, types and helper functions for the perspective vertex projection core
package ppv_pkg;

    // fixed point format of positions and screen coordinates
    localparam int FRAC_BITS  = 16;
    localparam int PRE_SH     = FRAC_BITS - 1;

    // field and register widths
    localparam int IN_W       = 32;
    localparam int CFG_W      = 14;
    localparam int STAT_W     = 2;

    // ratio magnitude is capped at 2^RATIO_LOG2
    localparam int RATIO_LOG2 = 40;
    localparam int QUO_W      = RATIO_LOG2;
    localparam int DIV_STAGES = QUO_W;
    localparam int CAP_SH     = RATIO_LOG2 - PRE_SH;

    // numerator |c| * h, partial remainder, centre and final sum widths
    localparam int NUM_W      = IN_W + CFG_W;
    localparam int REM_W      = IN_W;
    localparam int CEN_W      = CFG_W + PRE_SH;
    localparam int SUM_W      = RATIO_LOG2 + 3;

    // register reset values
    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

    // register indexes
    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } ppv_cfg_idx_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_ZDIV = 2'd1,
        STAT_SAT  = 2'd2
    } ppv_status_t;

    // fields carried alongside the arithmetic
    typedef struct packed {
        logic [IN_W-1:0] depth;
        logic [IN_W-1:0] tex_u;
        logic [IN_W-1:0] tex_v;
        logic [IN_W-1:0] norm_x;
        logic [IN_W-1:0] norm_y;
        logic [IN_W-1:0] norm_z;
        logic            zero;
    } ppv_side_t;

    // one divider lane: partial remainder, quotient so far, numerator, cap and sign
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [NUM_W-1:0] num;
        logic             cap;
        logic             neg;
    } ppv_lane_t;

    // one restoring division step, one quotient bit
    function automatic ppv_lane_t div_step(ppv_lane_t l, logic [REM_W-1:0] d, logic nbit);
        logic [REM_W:0] trial;
        ppv_lane_t      r;
        r     = l;
        trial = {l.rem, nbit};
        if (trial >= {1'b0, d}) begin
            r.rem = REM_W'(trial - {1'b0, d});
            r.quo = {l.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = trial[REM_W-1:0];
            r.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // clamp to the signed 32-bit range, flag in the top bit
    function automatic logic [IN_W:0] sat_s32(logic [SUM_W-1:0] v);
        logic fits;
        fits = (v[SUM_W-1:IN_W-1] == '0) || (v[SUM_W-1:IN_W-1] == '1);
        if (fits) begin
            return {1'b0, v[IN_W-1:0]};
        end else if (v[SUM_W-1]) begin
            return {1'b1, 1'b1, {(IN_W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(IN_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ hw/rtl/perspective_project_vertex_core.sv @@
// top level of the perspective vertex projection core
//
// Projects one view-space vertex per item to screen space:
// screen_x = W/2 + trunc(x*H/(2z)), screen_y = H/2 - trunc(y*H/(2z)), signed Q16.16,
// saturated to 32 bits (status 2); a depth of zero returns the screen centre with
// status 1. Depth, texture and normal fields are copied. The core takes one item
// every cycle while the pipeline is not held. From acceptance to m_valid an item
// passes an abs stage, a 32x14 multiply stage, a divider setup stage, a 40-stage
// restoring divider with one quotient bit per stage for x and y in parallel, and the
// output register. The whole pipeline advances together and holds while the output
// register is full and m_ready is low. Register writes take effect at once and are
// to be made only while no item is in flight.
module perspective_project_vertex_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_idx,
    input  logic [ppv_pkg::CFG_W-1:0]   cfg_data,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_pos_x,
    input  logic signed [31:0]          s_pos_y,
    input  logic signed [31:0]          s_pos_z,
    input  logic signed [31:0]          s_tex_u,
    input  logic signed [31:0]          s_tex_v,
    input  logic signed [31:0]          s_normal_x,
    input  logic signed [31:0]          s_normal_y,
    input  logic signed [31:0]          s_normal_z,
    // result items
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_screen_x,
    output logic signed [31:0]          m_screen_y,
    output logic signed [31:0]          m_depth_out,
    output logic signed [31:0]          m_tex_u_out,
    output logic signed [31:0]          m_tex_v_out,
    output logic signed [31:0]          m_normal_x_out,
    output logic signed [31:0]          m_normal_y_out,
    output logic signed [31:0]          m_normal_z_out,
    output logic [ppv_pkg::STAT_W-1:0]  m_status
);

    localparam int ND = ppv_pkg::DIV_STAGES;

    // configuration registers
    logic [ppv_pkg::CFG_W-1:0] width_reg;
    logic [ppv_pkg::CFG_W-1:0] height_reg;

    // pipeline advance
    logic en;

    // stage 1: magnitudes and signs
    logic                     s1_vld_reg;
    ppv_pkg::ppv_side_t       s1_side_reg;
    logic [ppv_pkg::IN_W-1:0] s1_ax_reg, s1_ay_reg, s1_az_reg;
    logic                     s1_negx_reg, s1_negy_reg;
    logic [ppv_pkg::IN_W-1:0] ax_next, ay_next, az_next;
    ppv_pkg::ppv_side_t       side_next;

    // stage 2: numerators
    logic                      s2_vld_reg;
    ppv_pkg::ppv_side_t        s2_side_reg;
    logic [ppv_pkg::NUM_W-1:0] s2_nx_reg, s2_ny_reg;
    logic [ppv_pkg::IN_W-1:0]  s2_az_reg;
    logic                      s2_negx_reg, s2_negy_reg;

    // divider stages
    logic                      dv_vld_reg  [0:ND];
    ppv_pkg::ppv_side_t        dv_side_reg [0:ND];
    ppv_pkg::ppv_lane_t        dv_x_reg    [0:ND];
    ppv_pkg::ppv_lane_t        dv_y_reg    [0:ND];
    logic [ppv_pkg::REM_W-1:0] dv_d_reg    [0:ND];
    ppv_pkg::ppv_lane_t        dv_x_next   [1:ND];
    ppv_pkg::ppv_lane_t        dv_y_next   [1:ND];
    ppv_pkg::ppv_lane_t        init_x, init_y;

    // final stage
    logic [ppv_pkg::CEN_W-1:0] cen_x, cen_y;
    logic [ppv_pkg::SUM_W-1:0] mag_x, mag_y, rat_x, rat_y, sum_x, sum_y;
    logic [ppv_pkg::IN_W:0]    sat_x, sat_y;
    ppv_pkg::ppv_status_t      status_next;

    // output register
    logic                     out_vld_reg;
    ppv_pkg::ppv_side_t       out_side_reg;
    logic [ppv_pkg::IN_W-1:0] out_sx_reg, out_sy_reg;
    ppv_pkg::ppv_status_t     out_stat_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ppv_pkg::WIDTH_RST;
            height_reg <= ppv_pkg::HEIGHT_RST;
        end else if (cfg_we) begin
            case (ppv_pkg::ppv_cfg_idx_t'(cfg_idx))
                ppv_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                ppv_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output slot frees
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // stage 1 logic: absolute values
    always_comb begin
        ax_next          = s_pos_x[31] ? 32'(-s_pos_x) : s_pos_x;
        ay_next          = s_pos_y[31] ? 32'(-s_pos_y) : s_pos_y;
        az_next          = s_pos_z[31] ? 32'(-s_pos_z) : s_pos_z;
        side_next.depth  = s_pos_z;
        side_next.tex_u  = s_tex_u;
        side_next.tex_v  = s_tex_v;
        side_next.norm_x = s_normal_x;
        side_next.norm_y = s_normal_y;
        side_next.norm_z = s_normal_z;
        side_next.zero   = (s_pos_z == '0);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= ND; k++) begin
                dv_vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            s1_vld_reg    <= s_valid;
            s2_vld_reg    <= s1_vld_reg;
            dv_vld_reg[0] <= s2_vld_reg;
            for (int k = 1; k <= ND; k++) begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
            out_vld_reg   <= dv_vld_reg[ND];
        end
    end

    // stage 1 and stage 2 payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= side_next;
            s1_ax_reg   <= ax_next;
            s1_ay_reg   <= ay_next;
            s1_az_reg   <= az_next;
            s1_negx_reg <= s_pos_x[31] ^ s_pos_z[31];
            s1_negy_reg <= s_pos_y[31] ^ s_pos_z[31];

            s2_side_reg <= s1_side_reg;
            s2_nx_reg   <= ppv_pkg::NUM_W'(s1_ax_reg * height_reg);
            s2_ny_reg   <= ppv_pkg::NUM_W'(s1_ay_reg * height_reg);
            s2_az_reg   <= s1_az_reg;
            s2_negx_reg <= s1_negx_reg;
            s2_negy_reg <= s1_negy_reg;
        end
    end

    // divider setup: leading remainder and cap detection
    always_comb begin
        init_x.num = s2_nx_reg;
        init_x.rem = ppv_pkg::REM_W'(s2_nx_reg >> ppv_pkg::CAP_SH);
        init_x.quo = '0;
        init_x.cap = (s2_nx_reg >> ppv_pkg::CAP_SH) >= ppv_pkg::NUM_W'(s2_az_reg);
        init_x.neg = s2_negx_reg;
        init_y.num = s2_ny_reg;
        init_y.rem = ppv_pkg::REM_W'(s2_ny_reg >> ppv_pkg::CAP_SH);
        init_y.quo = '0;
        init_y.cap = (s2_ny_reg >> ppv_pkg::CAP_SH) >= ppv_pkg::NUM_W'(s2_az_reg);
        init_y.neg = s2_negy_reg;
    end

    // divider steps, one quotient bit per stage
    always_comb begin : div_comb
        int   qi;
        logic bx, by;
        for (int k = 1; k <= ND; k++) begin
            qi = ND - k;
            if (qi >= ppv_pkg::PRE_SH) begin
                bx = dv_x_reg[k-1].num[qi - ppv_pkg::PRE_SH];
                by = dv_y_reg[k-1].num[qi - ppv_pkg::PRE_SH];
            end else begin
                bx = 1'b0;
                by = 1'b0;
            end
            dv_x_next[k] = ppv_pkg::div_step(dv_x_reg[k-1], dv_d_reg[k-1], bx);
            dv_y_next[k] = ppv_pkg::div_step(dv_y_reg[k-1], dv_d_reg[k-1], by);
        end
    end

    // divider stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_side_reg[0] <= s2_side_reg;
            dv_x_reg[0]    <= init_x;
            dv_y_reg[0]    <= init_y;
            dv_d_reg[0]    <= s2_az_reg;
            for (int k = 1; k <= ND; k++) begin
                dv_side_reg[k] <= dv_side_reg[k-1];
                dv_x_reg[k]    <= dv_x_next[k];
                dv_y_reg[k]    <= dv_y_next[k];
                dv_d_reg[k]    <= dv_d_reg[k-1];
            end
        end
    end

    // final stage: sign, centre offset, saturation, status
    always_comb begin
        cen_x = {width_reg,  {ppv_pkg::PRE_SH{1'b0}}};
        cen_y = {height_reg, {ppv_pkg::PRE_SH{1'b0}}};
        mag_x = dv_x_reg[ND].cap ? (ppv_pkg::SUM_W'(1) << ppv_pkg::RATIO_LOG2)
                                 : ppv_pkg::SUM_W'(dv_x_reg[ND].quo);
        mag_y = dv_y_reg[ND].cap ? (ppv_pkg::SUM_W'(1) << ppv_pkg::RATIO_LOG2)
                                 : ppv_pkg::SUM_W'(dv_y_reg[ND].quo);
        rat_x = dv_x_reg[ND].neg ? ppv_pkg::SUM_W'(-mag_x) : mag_x;
        rat_y = dv_y_reg[ND].neg ? ppv_pkg::SUM_W'(-mag_y) : mag_y;
        if (dv_side_reg[ND].zero) begin
            sum_x = ppv_pkg::SUM_W'(cen_x);
            sum_y = ppv_pkg::SUM_W'(cen_y);
        end else begin
            sum_x = ppv_pkg::SUM_W'(ppv_pkg::SUM_W'(cen_x) + rat_x);
            sum_y = ppv_pkg::SUM_W'(ppv_pkg::SUM_W'(cen_y) - rat_y);
        end
        sat_x = ppv_pkg::sat_s32(sum_x);
        sat_y = ppv_pkg::sat_s32(sum_y);
        if (dv_side_reg[ND].zero) begin
            status_next = ppv_pkg::STAT_ZDIV;
        end else if (sat_x[ppv_pkg::IN_W] || sat_y[ppv_pkg::IN_W]) begin
            status_next = ppv_pkg::STAT_SAT;
        end else begin
            status_next = ppv_pkg::STAT_OK;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (en) begin
            out_side_reg <= dv_side_reg[ND];
            out_sx_reg   <= sat_x[ppv_pkg::IN_W-1:0];
            out_sy_reg   <= sat_y[ppv_pkg::IN_W-1:0];
            out_stat_reg <= status_next;
        end
    end

    // result ports
    assign m_valid        = out_vld_reg;
    assign m_screen_x     = out_sx_reg;
    assign m_screen_y     = out_sy_reg;
    assign m_depth_out    = out_side_reg.depth;
    assign m_tex_u_out    = out_side_reg.tex_u;
    assign m_tex_v_out    = out_side_reg.tex_v;
    assign m_normal_x_out = out_side_reg.norm_x;
    assign m_normal_y_out = out_side_reg.norm_y;
    assign m_normal_z_out = out_side_reg.norm_z;
    assign m_status       = out_stat_reg;

    // depth fault is reported exactly for items whose depth is zero
    a_zdiv_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ppv_pkg::STAT_ZDIV) |-> (m_depth_out == '0))
        else $error("depth fault on nonzero depth");

    a_depth_zdiv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_depth_out == '0) |-> (m_status == ppv_pkg::STAT_ZDIV))
        else $error("zero depth without depth fault");

    // a stall freezes the pipeline occupancy
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(s1_vld_reg) && $stable(s2_vld_reg) && $stable(dv_vld_reg[ND]))
        else $error("pipeline moved during stall");

    // an accepted item enters the first stage
    a_accept_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> s1_vld_reg)
        else $error("accepted item lost at pipeline entry");

endmodule
